/* sv/ovn_tile_pkg.sv */
// ovn_tile_pkg: shared constants and helpers for the octave value noise tile classifier
// depends on nothing; imported by the classifier top level and its checker
`timescale 1ns / 1ps

package ovn_tile_pkg;

  // grid geometry
  localparam int MAX_SIDE_LOG2 = 6;
  localparam int COORD_W       = 6;
  localparam int ADDR_W        = 2 * MAX_SIDE_LOG2;
  localparam int DEPTH         = 1 << ADDR_W;

  // datapath widths
  localparam int SEED_W     = 16;
  localparam int LOG_W      = 3;
  localparam int CNT_W      = 3;
  localparam int PITCH_W    = MAX_SIDE_LOG2 + 1;
  localparam int WEIGHT_W   = ADDR_W + 1;
  localparam int PROD_W     = SEED_W + WEIGHT_W;
  localparam int TOTAL_W    = PROD_W + CNT_W;
  localparam int DIVIDEND_W = SEED_W + CNT_W;
  localparam int STEP_W     = $clog2(DIVIDEND_W);
  localparam int CFG_W      = 16;

  // configuration register indexes
  localparam logic [2:0] CFG_SIDE_LOG2    = 3'd0;
  localparam logic [2:0] CFG_OCTAVE_COUNT = 3'd1;
  localparam logic [2:0] CFG_ROCK_LIMIT   = 3'd2;
  localparam logic [2:0] CFG_GRASS_LIMIT  = 3'd3;
  localparam logic [2:0] CFG_SAND_LIMIT   = 3'd4;

  // configuration reset values
  localparam logic [LOG_W-1:0]  SIDE_LOG2_RST    = 3'd5;
  localparam logic [CNT_W-1:0]  OCTAVE_COUNT_RST = 3'd4;
  localparam logic [SEED_W-1:0] ROCK_LIMIT_RST   = 16'd20972;
  localparam logic [SEED_W-1:0] GRASS_LIMIT_RST  = 16'd39322;
  localparam logic [SEED_W-1:0] SAND_LIMIT_RST   = 16'd42598;

  // opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // tile classes
  localparam logic [1:0] TILE_ROCK  = 2'd0;
  localparam logic [1:0] TILE_GRASS = 2'd1;
  localparam logic [1:0] TILE_SAND  = 2'd2;
  localparam logic [1:0] TILE_WATER = 2'd3;

  // clamp the side log2 to the supported range
  function automatic logic [LOG_W-1:0] eff_side_log2(input logic [LOG_W-1:0] raw);
    logic [LOG_W-1:0] l;
    l = raw;
    if (raw == '0) l = LOG_W'(1);
    else if (raw > LOG_W'(MAX_SIDE_LOG2)) l = LOG_W'(MAX_SIDE_LOG2);
    return l;
  endfunction

  // seed store address of a cell: row * side + column
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                  input logic [COORD_W-1:0] y,
                                                  input logic [LOG_W-1:0]   l);
    logic [ADDR_W-1:0] row;
    row = ADDR_W'(y) << l;
    return row | ADDR_W'(x);
  endfunction

endpackage

/* sv/octave_value_noise_tile_classifier.sv */
// octave value noise tile classifier: seed store, octave blend, averaging and classification
// depends on ovn_tile_pkg
`timescale 1ns / 1ps
// A seed write leaves the block idle, so it takes the next transaction in the following cycle.
// A query (C = effective octave count, 1..7) makes one seed read per cycle from the single-port
// seed memory (4*C reads), drains the multiply-accumulate pipe, divides the 19-bit dividend
// by C bit-serially, then classifies once the output register is free of a stalled result.
// The result sits in an output register while the next query runs.
// Reset restores the configuration registers; seed memory contents are not cleared.

module octave_value_noise_tile_classifier
  import ovn_tile_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // configuration write port
  input  logic                cfg_wr_en,
  input  logic [2:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                opcode,
  input  logic [COORD_W-1:0]  cell_x,
  input  logic [COORD_W-1:0]  cell_y,
  input  logic [SEED_W-1:0]   seed_value,
  // output channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          tile_type,
  output logic [SEED_W-1:0]   noise_value
);

  typedef enum logic [2:0] {
    IDLE,
    RUN,
    DRAIN,
    DIV,
    DONE
  } state_t;

  state_t state;

  // configuration registers
  logic [LOG_W-1:0]  side_log2;
  logic [CNT_W-1:0]  octave_count;
  logic [SEED_W-1:0] rock_limit;
  logic [SEED_W-1:0] grass_limit;
  logic [SEED_W-1:0] sand_limit;

  // query context
  logic [COORD_W-1:0] q_x;
  logic [COORD_W-1:0] q_y;
  logic [COORD_W-1:0] q_mask;
  logic [LOG_W-1:0]   q_l;
  logic [CNT_W-1:0]   q_cnt;
  logic [CNT_W-1:0]   oct;
  logic [1:0]         corner;

  // accumulate pipe
  logic                s1_valid;
  logic [WEIGHT_W-1:0] s1_weight;
  logic                s2_valid;
  logic [PROD_W-1:0]   s2_prod;
  logic [TOTAL_W-1:0]  total;

  // divider
  logic [DIVIDEND_W-1:0] div_shift;
  logic [CNT_W-1:0]      rem;
  logic [STEP_W-1:0]     div_step;

  // seed memory
  logic [SEED_W-1:0] seed_mem [DEPTH];
  logic [SEED_W-1:0] rd_data;
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_we;
  logic              mem_re;

  // combinational signals
  logic               in_accept;
  logic [LOG_W-1:0]   l_eff;
  logic [COORD_W-1:0] coord_mask;
  logic [COORD_W-1:0] in_x;
  logic [COORD_W-1:0] in_y;
  logic [CNT_W-1:0]   cnt_eff;
  logic [LOG_W-1:0]   pl;
  logic [PITCH_W-1:0] pitch;
  logic [COORD_W-1:0] pmask;
  logic [COORD_W-1:0] bx;
  logic [COORD_W-1:0] by;
  logic [COORD_W-1:0] x1;
  logic [COORD_W-1:0] y1;
  logic [COORD_W-1:0] x2;
  logic [COORD_W-1:0] y2;
  logic [PITCH_W-1:0] wx;
  logic [PITCH_W-1:0] wy;
  logic [WEIGHT_W-1:0] wprod;
  logic [WEIGHT_W-1:0] weight;
  logic [ADDR_W-1:0]  rd_addr;
  logic               last_issue;
  logic [LOG_W:0]     rem_sh;
  logic               rem_ge;
  logic [SEED_W-1:0]  noise_sat;
  logic [1:0]         tile_sel;
  logic               out_free;

  // input side decode and clamping
  assign in_stall   = (state != IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign l_eff      = eff_side_log2(side_log2);
  assign coord_mask = ~({COORD_W{1'b1}} << l_eff);
  assign in_x       = cell_x & coord_mask;
  assign in_y       = cell_y & coord_mask;

  always_comb begin
    cnt_eff = octave_count;
    if (octave_count == '0) begin
      cnt_eff = CNT_W'(1);
    end else if (octave_count > CNT_W'(l_eff + LOG_W'(1))) begin
      cnt_eff = CNT_W'(l_eff + LOG_W'(1));
    end
  end

  // corner address and bilinear weight for the current octave and corner
  assign pl     = q_l - LOG_W'(oct);
  assign pitch  = PITCH_W'(1) << pl;
  assign pmask  = pitch[COORD_W-1:0] - COORD_W'(1);
  assign bx     = q_x & pmask;
  assign by     = q_y & pmask;
  assign x1     = q_x & ~pmask;
  assign y1     = q_y & ~pmask;
  assign x2     = (x1 + pitch[COORD_W-1:0]) & q_mask;
  assign y2     = (y1 + pitch[COORD_W-1:0]) & q_mask;
  assign wx     = corner[0] ? PITCH_W'(bx) : pitch - PITCH_W'(bx);
  assign wy     = corner[1] ? PITCH_W'(by) : pitch - PITCH_W'(by);
  assign wprod  = WEIGHT_W'(wx * wy);
  assign weight = wprod << {oct, 1'b0};
  assign rd_addr = cell_addr(corner[0] ? x2 : x1, corner[1] ? y2 : y1, q_l);
  assign last_issue = (corner == 2'd3) && (oct == q_cnt - CNT_W'(1));

  // memory port: seed writes while idle, corner reads while running
  assign mem_we   = in_accept && (opcode == OP_WRITE);
  assign mem_re   = (state == RUN);
  assign mem_addr = (state == IDLE) ? cell_addr(in_x, in_y, l_eff) : rd_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      seed_mem[mem_addr] <= seed_value;
    end
    if (mem_re) begin
      rd_data <= seed_mem[mem_addr];
    end
  end

  // one restoring division step by the octave count
  assign rem_sh = {rem, div_shift[DIVIDEND_W-1]};
  assign rem_ge = (rem_sh >= (LOG_W+1)'(q_cnt));

  // saturate and classify
  assign noise_sat = (|div_shift[DIVIDEND_W-1:SEED_W]) ? {SEED_W{1'b1}}
                                                       : div_shift[SEED_W-1:0];
  always_comb begin
    if (noise_sat < rock_limit) tile_sel = TILE_ROCK;
    else if (noise_sat < grass_limit) tile_sel = TILE_GRASS;
    else if (noise_sat < sand_limit) tile_sel = TILE_SAND;
    else tile_sel = TILE_WATER;
  end

  assign out_free = !out_valid || !out_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      side_log2    <= SIDE_LOG2_RST;
      octave_count <= OCTAVE_COUNT_RST;
      rock_limit   <= ROCK_LIMIT_RST;
      grass_limit  <= GRASS_LIMIT_RST;
      sand_limit   <= SAND_LIMIT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SIDE_LOG2:    side_log2    <= cfg_data[LOG_W-1:0];
        CFG_OCTAVE_COUNT: octave_count <= cfg_data[CNT_W-1:0];
        CFG_ROCK_LIMIT:   rock_limit   <= cfg_data[SEED_W-1:0];
        CFG_GRASS_LIMIT:  grass_limit  <= cfg_data[SEED_W-1:0];
        CFG_SAND_LIMIT:   sand_limit   <= cfg_data[SEED_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer, accumulate pipe, divider and output register
  always_ff @(posedge clk) begin
    // payload registers
    s1_weight <= weight;
    s2_prod   <= PROD_W'(rd_data * s1_weight);
    if (s2_valid) begin
      total <= total + TOTAL_W'(s2_prod);
    end

    if (rst) begin
      state     <= IDLE;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid <= mem_re;
      s2_valid <= s1_valid;
      // result taken and no new one replacing it this cycle
      if (out_valid && !out_stall && (state != DONE)) begin
        out_valid <= 1'b0;
      end

      case (state)
        IDLE: begin
          if (in_accept && (opcode == OP_QUERY)) begin
            q_x    <= in_x;
            q_y    <= in_y;
            q_mask <= coord_mask;
            q_l    <= l_eff;
            q_cnt  <= cnt_eff;
            oct    <= '0;
            corner <= '0;
            total  <= '0;
            state  <= RUN;
          end
        end
        RUN: begin
          corner <= corner + 2'd1;
          if (corner == 2'd3) begin
            oct <= oct + CNT_W'(1);
          end
          if (last_issue) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          if (!s1_valid && !s2_valid) begin
            div_shift <= DIVIDEND_W'(total >> {q_l, 1'b0});
            rem       <= '0;
            div_step  <= '0;
            state     <= DIV;
          end
        end
        DIV: begin
          rem       <= rem_ge ? CNT_W'(rem_sh - (LOG_W+1)'(q_cnt)) : rem_sh[CNT_W-1:0];
          div_shift <= {div_shift[DIVIDEND_W-2:0], rem_ge};
          div_step  <= div_step + STEP_W'(1);
          if (div_step == STEP_W'(DIVIDEND_W - 1)) begin
            state <= DONE;
          end
        end
        DONE: begin
          if (out_free) begin
            noise_value <= noise_sat;
            tile_type   <= tile_sel;
            out_valid   <= 1'b1;
            state       <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/ovn_tile_chk.sv */
// ovn_tile_chk: port-level checker for the octave value noise tile classifier, with its bind
// depends on ovn_tile_pkg and octave_value_noise_tile_classifier
`timescale 1ns / 1ps

module ovn_tile_chk
  import ovn_tile_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              opcode,
  input logic              out_valid,
  input logic              out_stall,
  input logic [1:0]        tile_type,
  input logic [SEED_W-1:0] noise_value
);

  logic in_accept;
  assign in_accept = in_valid && !in_stall;

  // reset empties the output register
  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(noise_value) && $stable(tile_type))
    else $error("stalled result changed");

  // a query keeps the block busy in the following cycle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_accept && (opcode == OP_QUERY) |=> in_stall)
    else $error("query did not hold off input");

  // a seed write leaves the input open in the following cycle and produces no result
  a_write_quick: assert property (@(posedge clk) disable iff (rst)
    in_accept && (opcode == OP_WRITE) |=> !in_stall && !$rose(out_valid))
    else $error("seed write stalled input or produced a result");

endmodule

bind octave_value_noise_tile_classifier ovn_tile_chk u_ovn_tile_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .opcode      (opcode),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .tile_type   (tile_type),
  .noise_value (noise_value)
);
